// ----- rtl/core/dhot_pkg.sv -----
// ----------------------------------------------------------------------------
// dhot_pkg
// Shared types and constants for the double-hashing open table.
// ----------------------------------------------------------------------------
package dhot_pkg;

  localparam int unsigned TableSlots = 1021;
  localparam int unsigned IdxW       = $clog2(TableSlots);
  localparam int unsigned CntW       = 10;
  localparam int unsigned FullLimit  = (TableSlots * 3 + 3) / 4;
  localparam int unsigned StepMod    = TableSlots - 2;

  // Residues of 2^10 and 2^20, used to fold the 29-bit hash.
  localparam int unsigned FoldA1     = 1024 % TableSlots;
  localparam int unsigned FoldA2     = (1024 * 1024) % TableSlots;
  localparam int unsigned FoldB1     = 1024 % StepMod;
  localparam int unsigned FoldB2     = (1024 * 1024) % StepMod;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MK_EMPTY = 2'd0,
    MK_TOMB  = 2'd1,
    MK_LIVE  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_OUT
  } state_t;

endpackage

// ----- rtl/core/dhot_ram.sv -----
// ----------------------------------------------------------------------------
// dhot_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dhot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/double_hash_open_table.sv -----
// ----------------------------------------------------------------------------
// double_hash_open_table
// Open-addressing key/value table with double hashing over a prime slot count.
// ----------------------------------------------------------------------------
// Usage: one operation (find, insert, remove, clear) is accepted per transfer
// on the in_ channel; exactly one result transfer follows on the out_ channel
// with status, found_value and live_count. Marks sit in one single-port RAM and
// key/value pairs in another, both with a registered read. The hash is
// reduced modulo the slot count and modulo the slot count minus two by two
// folding steps, one per cycle, which yield the first probe and the step. Each
// probe then takes a RAM read state and then a compare state. A clear sweeps
// all 1021 mark entries, one per cycle. An insert that ends at an empty slot
// after passing tombstones writes the first tombstone it met, so no second
// probe pass is needed. After reset the block sweeps the mark RAM to empty and
// accepts nothing meanwhile. The result stays on the out_ ports until taken;
// a new item is accepted only after the result transfer, so a stalled
// receiver simply holds the block.
// ----------------------------------------------------------------------------
module double_hash_open_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [9:0]  out_live_count
);

  import dhot_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]      op_r;
  logic [31:0]     key_r, val_r;
  logic [28:0]     hash_r;
  logic            phase_r;
  logic [14:0]     fold_a_r, fold_b_r;
  logic [IdxW-1:0] idx_r, step_r, tomb_r;
  logic            tomb_v_r;
  logic [IdxW:0]   n_r;
  logic [CntW-1:0] used_r, tombc_r;
  logic [1:0]      status_r;
  logic [31:0]     found_r;

  logic            we_mark, we_kv;
  logic [IdxW-1:0] addr;
  logic [1:0]      mark_wd, mark_rd;
  logic [63:0]     kv_rd;
  logic [31:0]     key_rd, val_rd;

  assign key_rd = kv_rd[63:32];
  assign val_rd = kv_rd[31:0];

  // First fold: the hash is split into 10-, 10- and 9-bit digits weighted by the
  // residues of 2^10 and 2^20. The second fold leaves at most one subtraction.
  logic [14:0] fold_a, fold_b;
  assign fold_a = 15'(hash_r[9:0]) + 15'(hash_r[19:10]) * 15'(FoldA1) +
                  15'(hash_r[28:20]) * 15'(FoldA2);
  assign fold_b = 15'(hash_r[9:0]) + 15'(hash_r[19:10]) * 15'(FoldB1) +
                  15'(hash_r[28:20]) * 15'(FoldB2);

  logic [IdxW:0] red_a, red_b;
  assign red_a = (IdxW+1)'(fold_a_r[9:0]) + (IdxW+1)'(fold_a_r[14:10]) * (IdxW+1)'(FoldA1);
  assign red_b = (IdxW+1)'(fold_b_r[9:0]) + (IdxW+1)'(fold_b_r[14:10]) * (IdxW+1)'(FoldB1);

  logic [IdxW:0] nidx;
  assign nidx = {1'b0, idx_r} + {1'b0, step_r};

  logic is_empty, is_tomb, is_hit, last_probe, full;
  assign is_empty   = (mark_rd == MK_EMPTY);
  assign is_tomb    = (mark_rd == MK_TOMB);
  assign is_hit     = (mark_rd == MK_LIVE) && (key_rd == key_r);
  assign last_probe = (n_r == (IdxW+1)'(TableSlots - 1));
  assign full       = (used_r >= CntW'(FullLimit));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_opcode == OP_CLEAR) ? S_CLEAR : S_HASH;
      S_HASH:  if (phase_r) state_nxt = S_READ;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: if (is_empty || is_hit || last_probe) state_nxt = S_OUT;
               else state_nxt = S_READ;
      S_CLEAR: if (idx_r == IdxW'(TableSlots - 1)) state_nxt = (op_r == OP_CLEAR) ? S_OUT : S_IDLE;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Write decisions at the end of a probe, and the mark writes of a clear sweep.
  logic ins_ok;
  logic [IdxW-1:0] ins_at;
  always_comb begin
    ins_ok = 1'b0;
    ins_at = idx_r;
    we_mark = 1'b0;
    we_kv = 1'b0;
    mark_wd = MK_EMPTY;
    addr = idx_r;
    if (state_r == S_CLEAR) begin
      we_mark = 1'b1;
    end else if (state_r == S_CHECK) begin
      if (is_hit) begin
        if (op_r == OP_REMOVE) begin
          we_mark = 1'b1;
          mark_wd = MK_TOMB;
        end else if (op_r == OP_INSERT) begin
          we_kv = 1'b1;
          we_mark = 1'b1;
          mark_wd = MK_LIVE;
        end
      end else if ((is_empty || last_probe) && op_r == OP_INSERT && !full) begin
        if (tomb_v_r) begin
          ins_ok = 1'b1;
          ins_at = tomb_r;
        end else if (last_probe && is_tomb) begin
          ins_ok = 1'b1;
        end else if (is_empty) begin
          ins_ok = 1'b1;
        end
        we_mark = ins_ok;
        we_kv = ins_ok;
        mark_wd = MK_LIVE;
        addr = ins_at;
      end
    end
  end

  dhot_ram #(.Width(2), .Depth(TableSlots)) u_mark (
    .clk(clk), .we(we_mark), .addr(addr), .wdata(mark_wd), .rdata(mark_rd));
  dhot_ram #(.Width(64), .Depth(TableSlots)) u_kv (
    .clk(clk), .we(we_kv), .addr(addr), .wdata({key_r, val_r}), .rdata(kv_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= OP_FIND;
      idx_r   <= '0;
      used_r  <= '0;
      tombc_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r    <= in_opcode;
          key_r   <= in_key;
          val_r   <= in_value;
          hash_r  <= in_key[31:3];
          phase_r <= 1'b0;
          idx_r   <= '0;
          status_r <= ST_DONE;
          found_r  <= '0;
        end
        S_HASH: begin
          fold_a_r <= fold_a;
          fold_b_r <= fold_b;
          phase_r  <= 1'b1;
          if (phase_r) begin
            idx_r  <= (red_a >= (IdxW+1)'(TableSlots)) ?
                      IdxW'(red_a - (IdxW+1)'(TableSlots)) : IdxW'(red_a);
            step_r <= IdxW'(((red_b >= (IdxW+1)'(StepMod)) ?
                      red_b - (IdxW+1)'(StepMod) : red_b) + 1'b1);
            n_r      <= '0;
            tomb_v_r <= 1'b0;
          end
        end
        S_CHECK: begin
          idx_r <= (nidx >= (IdxW+1)'(TableSlots)) ?
                   IdxW'(nidx - (IdxW+1)'(TableSlots)) : IdxW'(nidx);
          n_r <= n_r + 1'b1;
          if (is_tomb && !tomb_v_r) begin
            tomb_v_r <= 1'b1;
            tomb_r   <= idx_r;
          end
          if (is_hit) begin
            if (op_r == OP_FIND) found_r <= val_rd;
            if (op_r == OP_REMOVE) tombc_r <= tombc_r + 1'b1;
          end else if (is_empty || last_probe) begin
            if (op_r != OP_INSERT) status_r <= ST_ABSENT;
            else if (!ins_ok) status_r <= ST_FULL;
            else if (tomb_v_r || !is_empty) tombc_r <= tombc_r - 1'b1;
            else used_r <= used_r + 1'b1;
          end
        end
        S_CLEAR: begin
          idx_r   <= idx_r + 1'b1;
          used_r  <= '0;
          tombc_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_found_value = found_r;
  assign out_live_count  = used_r - tombc_r;

  a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tombc_r <= used_r)) else $error("tombstones exceed used slots");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("both channels open");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(FullLimit)) else $error("used count over limit");

endmodule

// ----- test/double_hash_open_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_table_test
// Self-checking bench for the double-hashing open table. A queue of table
// operations feeds a clocked driver; a clocked monitor compares every result
// transfer with a software copy of the table kept in step with the stimulus.
// ----------------------------------------------------------------------------
module double_hash_open_table_test;
  import dhot_pkg::*;

  localparam int unsigned Slots = TableSlots;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] key;
    logic [31:0] value;
  } table_op_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic [9:0]  live_count;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_found_value;
  logic [9:0]  out_live_count;

  double_hash_open_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_value(out_found_value),
    .out_live_count(out_live_count)
  );

  // Shadow copy of the table contents and its occupancy counters.
  mark_t       shadow_mark [Slots];
  logic [31:0] shadow_key [Slots];
  logic [31:0] shadow_value [Slots];
  int unsigned shadow_used;
  int unsigned shadow_tombs;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   full_refusals;
  int unsigned   tomb_reuses;
  int unsigned   idle_cycles;
  bit            hold_sender;
  bit            calm_stretch;

  // Walks the probe sequence the same way the block does. Returns 1 with the
  // live slot on a hit; otherwise first_tomb is the first tombstone passed
  // (Slots if none) and first_empty the empty slot that ended the probe.
  function automatic bit shadow_probe(input logic [31:0] key, output int unsigned hit,
                                      output int unsigned first_tomb,
                                      output int unsigned first_empty);
    int unsigned hash, idx, stride;
    hash = key >> 3;
    idx = hash % Slots;
    stride = 1 + hash % (Slots - 2);
    hit = 0;
    first_tomb = Slots;
    first_empty = Slots;
    for (int unsigned n = 0; n < Slots; n++) begin
      if (shadow_mark[idx] == MK_EMPTY) begin
        first_empty = idx;
        return 1'b0;
      end
      if (shadow_mark[idx] == MK_TOMB) begin
        if (first_tomb == Slots) first_tomb = idx;
      end else if (shadow_key[idx] == key) begin
        hit = idx;
        return 1'b1;
      end
      idx += stride;
      if (idx >= Slots) idx -= Slots;
    end
    return 1'b0;
  endfunction

  // Applies one operation to the shadow table and returns the result it yields.
  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t res;
    int unsigned hit, first_tomb, first_empty;
    bit present;
    res.status = ST_DONE;
    res.found_value = '0;
    if (op.opcode == OP_CLEAR) begin
      foreach (shadow_mark[i]) shadow_mark[i] = MK_EMPTY;
      shadow_used = 0;
      shadow_tombs = 0;
    end else begin
      present = shadow_probe(op.key, hit, first_tomb, first_empty);
      case (op.opcode)
        OP_FIND: begin
          if (present) res.found_value = shadow_value[hit];
          else res.status = ST_ABSENT;
        end
        OP_REMOVE: begin
          if (present) begin
            shadow_mark[hit] = MK_TOMB;
            shadow_tombs++;
          end else begin
            res.status = ST_ABSENT;
          end
        end
        default: begin
          if (present) begin
            shadow_value[hit] = op.value;
          end else if (shadow_used * 4 >= Slots * 3) begin
            res.status = ST_FULL;
            full_refusals++;
          end else if (first_tomb < Slots) begin
            shadow_mark[first_tomb] = MK_LIVE;
            shadow_key[first_tomb] = op.key;
            shadow_value[first_tomb] = op.value;
            shadow_tombs--;
            tomb_reuses++;
          end else if (first_empty < Slots) begin
            shadow_mark[first_empty] = MK_LIVE;
            shadow_key[first_empty] = op.key;
            shadow_value[first_empty] = op.value;
            shadow_used++;
          end else begin
            res.status = ST_FULL;
            full_refusals++;
          end
        end
      endcase
    end
    res.live_count = 10'(shadow_used - shadow_tombs);
    return res;
  endfunction

  function automatic table_op_t make_op(input op_t code, input logic [31:0] key,
                                        input logic [31:0] value);
    table_op_t op;
    op.opcode = code;
    op.key = key;
    op.value = value;
    return op;
  endfunction

  // Keys drawn from a small pool collide often (eight keys share each hash), so finds and removes hit more often.
  function automatic logic [31:0] pool_key(input int unsigned pool);
    return $urandom_range(pool - 1) * 32'h0000_0a38 + $urandom_range(7);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reset is asserted once, at the start of the run.
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: presents the oldest pending operation and keeps it stable until the
  // transfer. A new valid is only raised when the current one is not held.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_FIND;
      in_key <= '0;
      in_value <= '0;
    end else begin
      if (in_valid && in_ready) void'(pending_ops.pop_front());
      if (in_valid && !in_ready) begin
        // Hold the current item unchanged until it is accepted.
      end else if (pending_ops.size() != 0 && !hold_sender &&
                   (calm_stretch || $urandom_range(99) >= 15)) begin
        in_valid <= 1'b1;
        in_opcode <= pending_ops[0].opcode;
        in_key <= pending_ops[0].key;
        in_value <= pending_ops[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The shadow table advances on each accepted operation, in transfer order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(apply_table_op(make_op(op_t'(in_opcode), in_key, in_value)));
  end

  // Monitor: random back-pressure on the result side and a field-wise compare.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_stretch || $urandom_range(99) >= 15;
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d value %h live %0d",
                     out_status, out_found_value, out_live_count);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_found_value !== want.found_value ||
              out_live_count !== want.live_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected status %0d value %h live %0d, got %0d %h %0d",
                       result_count, want.status, want.found_value, want.live_count,
                       out_status, out_found_value, out_live_count);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= CycleLimit) begin
        $display("watchdog: no transfer for %0d cycles", CycleLimit);
        $display("double_hash_open_table_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] key;
    hold_sender = 1'b0;
    calm_stretch = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    full_refusals = 0;
    tomb_reuses = 0;
    shadow_used = 0;
    shadow_tombs = 0;
    foreach (shadow_mark[i]) begin
      shadow_mark[i] = MK_EMPTY;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end

    // Directed part: key and value extremes, every operation, a miss on an
    // empty table, an overwrite, a remove then tombstone reuse, absent
    // removes, and two keys that share a hash.
    pending_ops.push_back(make_op(OP_FIND, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_REMOVE, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h0, 32'hffff_ffff));
    pending_ops.push_back(make_op(OP_INSERT, 32'hffff_ffff, 32'h0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h1, 32'h5555_aaaa));
    pending_ops.push_back(make_op(OP_FIND, 32'h0, 32'h1234_5678));
    pending_ops.push_back(make_op(OP_FIND, 32'hffff_ffff, 32'h0));
    pending_ops.push_back(make_op(OP_FIND, 32'h1, 32'h0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h0, 32'haaaa_5555));
    pending_ops.push_back(make_op(OP_FIND, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_REMOVE, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_FIND, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_FIND, 32'h1, 32'h0));
    pending_ops.push_back(make_op(OP_REMOVE, 32'h0, 32'h0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h2, 32'h8000_0001));
    pending_ops.push_back(make_op(OP_FIND, 32'h2, 32'h0));
    pending_ops.push_back(make_op(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_ops.push_back(make_op(OP_INSERT, 32'h8000_0000, 32'h8000_0000));
    pending_ops.push_back(make_op(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff));
    pending_ops.push_back(make_op(OP_FIND, 32'hffff_ffff, 32'h0));
    pending_ops.push_back(make_op(OP_FIND, 32'h7fff_ffff, 32'h0));

    // Pause the sender until every result of the directed part is back. The
    // clock edge lets the last accepted item reach the expected queue first.
    wait (rst_n);
    wait (pending_ops.size() == 0);
    hold_sender = 1'b1;
    @(posedge clk);
    wait (expected_results.size() == 0);
    hold_sender = 1'b0;

    // Fill phase: enough distinct inserts to drive the table past the
    // three-quarter mark, so refusals for fullness are seen.
    for (int i = 0; i < 800; i++)
      pending_ops.push_back(make_op(OP_INSERT, $urandom, $urandom));
    pending_ops.push_back(make_op(OP_CLEAR, $urandom, $urandom));

    // Mixed phase, mostly on a small key pool, about a third of it without idling on either side.
    for (int i = 0; i < 880; i++) begin
      if (i == 300) begin
        wait (pending_ops.size() == 0);
        calm_stretch = 1'b1;
      end
      if (i == 600) begin
        wait (pending_ops.size() == 0);
        calm_stretch = 1'b0;
      end
      pick = $urandom_range(99);
      key = (pick < 90) ? pool_key(64) : $urandom;
      if (pick < 35) pending_ops.push_back(make_op(OP_INSERT, key, $urandom));
      else if (pick < 65) pending_ops.push_back(make_op(OP_FIND, key, $urandom));
      else if (pick < 98) pending_ops.push_back(make_op(OP_REMOVE, key, $urandom));
      else pending_ops.push_back(make_op(OP_CLEAR, key, $urandom));
    end

    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (2000) @(posedge clk);

    $display("%0d results checked; %0d full refusals, %0d tombstone reuses",
             result_count, full_refusals, tomb_reuses);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("double_hash_open_table_test OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_results.size());
      $display("double_hash_open_table_test NOT OK");
    end
    $finish;
  end

endmodule
